// ===== rtl/ape_tag_item_parser_core_assert.svh =====
// Assertion helpers shared by the parser RTL.
`ifndef APE_TAG_ITEM_PARSER_CORE_ASSERT_SVH
`define APE_TAG_ITEM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, inactive during reset.
`define ATP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive during reset.
`define ATP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/atp_pkg.sv =====
package atp_pkg;

  // Default tag size limit in bytes (footer included)
  localparam int unsigned MAX_TAG_BYTES = 1048576;
  // Default result queue depth (2 or more)
  localparam int unsigned QUEUE_DEPTH = 2;

  // "APETAGEX", byte 0 in the low bits
  localparam logic [63:0] APE_ID = 64'h5845_4741_5445_5041;
  localparam logic [31:0] APE_VERSION = 32'd2000;
  localparam logic [31:0] MIN_TAG_LEN = 32'd42;
  localparam logic [31:0] FOOTER_BYTES = 32'd32;
  localparam logic [4:0] FOOTER_LAST = 5'd31;
  localparam int unsigned MIN_BODY_LEFT = 10;

  typedef enum logic [2:0] {
    PH_FOOTER,
    PH_SIZE,
    PH_FLAGS,
    PH_KEY,
    PH_VALUE,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_VERDICT,
    KIND_KEY,
    KIND_VALUE,
    KIND_END
  } kind_e;

  // One result transaction
  typedef struct packed {
    kind_e       kind;
    logic        footer_ok;
    logic [7:0]  out_byte;
    logic [31:0] item_flags;
    logic [31:0] item_index;
    logic        key_last;
    logic        item_done;
    logic        item_dropped;
    logic        parse_done;
  } res_t;

endpackage

// ===== rtl/atp_front.sv =====
`include "ape_tag_item_parser_core_assert.svh"

module atp_front #(
  parameter int unsigned MaxTagBytes = atp_pkg::MAX_TAG_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         func_i,
  input  logic [7:0]   data_byte_i,
  output logic         in_stall_o,
  input  logic         q_full_i,
  output logic         push_o,
  output atp_pkg::res_t push_res_o
);

  localparam int unsigned BytesW = $clog2(MaxTagBytes + 1);
  localparam logic [31:0] MaxLen = 32'(MaxTagBytes);
  localparam logic [BytesW-1:0] MinLeft = BytesW'(atp_pkg::MIN_BODY_LEFT);

  atp_pkg::phase_e phase_q, phase_d;
  logic [4:0]        footer_pos_q;
  logic              id_ok_q;
  logic [31:0]       version_q;
  logic [31:0]       tag_len_q;
  logic [31:0]       items_q;
  logic [BytesW-1:0] bytes_q;
  logic [1:0]        word_pos_q;
  logic [31:0]       vsize_q;
  logic [31:0]       flags_q;
  logic [31:0]       index_q;
  logic [31:0]       vleft_q;

  logic              acc;
  logic              foot_byte;
  logic              body_byte;
  logic              foot_last;
  logic              footer_good;
  logic [BytesW-1:0] bytes_init;
  logic [BytesW-1:0] bytes_dec;
  logic              stop_foot;
  logic              stop_body;
  logic              key_nul;
  logic              key_over;
  logic [31:0]       vleft_dec;
  logic              val_last;

  // Accept whenever the result queue has room
  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign foot_byte  = acc && !func_i;
  assign body_byte  = acc && func_i;
  assign foot_last  = footer_pos_q == atp_pkg::FOOTER_LAST;

  // Footer verdict and body bookkeeping
  assign footer_good = id_ok_q && (version_q == atp_pkg::APE_VERSION)
                       && (tag_len_q > atp_pkg::MIN_TAG_LEN) && (tag_len_q <= MaxLen);
  assign bytes_init = BytesW'(tag_len_q - atp_pkg::FOOTER_BYTES);
  assign bytes_dec  = (bytes_q != '0) ? bytes_q - 1'b1 : bytes_q;
  assign stop_foot  = (items_q == '0) || (bytes_init <= MinLeft);
  assign stop_body  = (items_q == '0) || (bytes_dec <= MinLeft);
  assign key_nul    = data_byte_i == 8'd0;
  assign key_over   = 32'(bytes_dec) < vsize_q;
  assign vleft_dec  = (vleft_q != '0) ? vleft_q - 32'd1 : vleft_q;
  assign val_last   = vleft_dec == '0;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      atp_pkg::PH_FOOTER: begin
        if (foot_byte && foot_last) begin
          phase_d = (!footer_good || stop_foot) ? atp_pkg::PH_DONE : atp_pkg::PH_SIZE;
        end
      end
      atp_pkg::PH_SIZE: begin
        if (body_byte && word_pos_q == 2'd3) begin
          phase_d = atp_pkg::PH_FLAGS;
        end
      end
      atp_pkg::PH_FLAGS: begin
        if (body_byte && word_pos_q == 2'd3) begin
          phase_d = atp_pkg::PH_KEY;
        end
      end
      atp_pkg::PH_KEY: begin
        if (body_byte) begin
          if (!key_nul) begin
            if (bytes_dec == '0) phase_d = atp_pkg::PH_DONE;
          end else if (key_over) begin
            phase_d = atp_pkg::PH_DONE;
          end else if (vsize_q == '0) begin
            phase_d = stop_body ? atp_pkg::PH_DONE : atp_pkg::PH_SIZE;
          end else begin
            phase_d = atp_pkg::PH_VALUE;
          end
        end
      end
      atp_pkg::PH_VALUE: begin
        if (body_byte && val_last) begin
          phase_d = stop_body ? atp_pkg::PH_DONE : atp_pkg::PH_SIZE;
        end
      end
      atp_pkg::PH_DONE: phase_d = atp_pkg::PH_DONE;
      default: phase_d = atp_pkg::PH_DONE;
    endcase
  end

  // Result classification
  always_comb begin
    push_o     = 1'b0;
    push_res_o = '0;
    case (phase_q)
      atp_pkg::PH_FOOTER: begin
        if (foot_byte && foot_last) begin
          push_o                = 1'b1;
          push_res_o.kind       = atp_pkg::KIND_VERDICT;
          push_res_o.footer_ok  = footer_good;
          push_res_o.parse_done = !footer_good || stop_foot;
        end
      end
      atp_pkg::PH_KEY: begin
        if (body_byte) begin
          push_o                = 1'b1;
          push_res_o.kind       = atp_pkg::KIND_KEY;
          push_res_o.out_byte   = data_byte_i;
          push_res_o.item_flags = flags_q;
          push_res_o.item_index = index_q;
          if (!key_nul) begin
            push_res_o.item_dropped = bytes_dec == '0;
            push_res_o.parse_done   = bytes_dec == '0;
          end else begin
            push_res_o.key_last = 1'b1;
            if (key_over) begin
              push_res_o.item_dropped = 1'b1;
              push_res_o.parse_done   = 1'b1;
            end else if (vsize_q == '0) begin
              push_res_o.item_done  = 1'b1;
              push_res_o.parse_done = stop_body;
            end
          end
        end
      end
      atp_pkg::PH_VALUE: begin
        if (body_byte) begin
          push_o                = 1'b1;
          push_res_o.kind       = atp_pkg::KIND_VALUE;
          push_res_o.out_byte   = data_byte_i;
          push_res_o.item_flags = flags_q;
          push_res_o.item_index = index_q;
          push_res_o.item_done  = val_last;
          push_res_o.parse_done = val_last && stop_body;
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= atp_pkg::PH_FOOTER;
      footer_pos_q <= '0;
      id_ok_q      <= 1'b1;
      version_q    <= '0;
      tag_len_q    <= '0;
      items_q      <= '0;
      bytes_q      <= '0;
      word_pos_q   <= '0;
      vsize_q      <= '0;
      flags_q      <= '0;
      index_q      <= '0;
      vleft_q      <= '0;
    end else begin
      phase_q <= phase_d;
      case (phase_q)
        atp_pkg::PH_FOOTER: begin
          if (foot_byte) begin
            footer_pos_q <= footer_pos_q + 5'd1;
            case (footer_pos_q[4:2])
              3'd0, 3'd1: begin
                if (data_byte_i != atp_pkg::APE_ID[8*footer_pos_q[2:0] +: 8]) begin
                  id_ok_q <= 1'b0;
                end
              end
              3'd2: version_q[8*footer_pos_q[1:0] +: 8] <= data_byte_i;
              3'd3: tag_len_q[8*footer_pos_q[1:0] +: 8] <= data_byte_i;
              3'd4: items_q[8*footer_pos_q[1:0] +: 8]   <= data_byte_i;
              default: ;
            endcase
            if (foot_last && footer_good) begin
              bytes_q <= bytes_init;
              index_q <= '0;
              if (!stop_foot) begin
                items_q    <= items_q - 32'd1;
                word_pos_q <= '0;
              end
            end
          end
        end
        atp_pkg::PH_SIZE, atp_pkg::PH_FLAGS: begin
          if (body_byte) begin
            bytes_q    <= bytes_dec;
            word_pos_q <= word_pos_q + 2'd1;
            if (phase_q == atp_pkg::PH_SIZE) begin
              vsize_q[8*word_pos_q +: 8] <= data_byte_i;
            end else begin
              flags_q[8*word_pos_q +: 8] <= data_byte_i;
            end
          end
        end
        atp_pkg::PH_KEY: begin
          if (body_byte) begin
            bytes_q <= bytes_dec;
            if (key_nul && !key_over) begin
              if (vsize_q == '0) begin
                index_q <= index_q + 32'd1;
                if (!stop_body) begin
                  items_q    <= items_q - 32'd1;
                  word_pos_q <= '0;
                end
              end else begin
                vleft_q <= vsize_q;
              end
            end
          end
        end
        atp_pkg::PH_VALUE: begin
          if (body_byte) begin
            bytes_q <= bytes_dec;
            vleft_q <= vleft_dec;
            if (val_last) begin
              index_q <= index_q + 32'd1;
              if (!stop_body) begin
                items_q    <= items_q - 32'd1;
                word_pos_q <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ATP_ASSERT_NXT(a_done_sticks, clk_i, rst_ni, phase_q == atp_pkg::PH_DONE, phase_q == atp_pkg::PH_DONE, "parser left the done phase")
  `ATP_ASSERT_IMP(a_push_needs_acc, clk_i, rst_ni, push_o, in_valid_i && !q_full_i, "result pushed without an accepted transaction")
  `ATP_ASSERT_NXT(a_pdone_stops, clk_i, rst_ni, push_o && push_res_o.parse_done, phase_q == atp_pkg::PH_DONE, "parse_done result did not stop the parser")

endmodule

// ===== rtl/atp_queue.sv =====
`include "ape_tag_item_parser_core_assert.svh"

module atp_queue #(
  parameter int unsigned Depth = atp_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  atp_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output atp_pkg::res_t out_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  atp_pkg::res_t   entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign full_o      = count_q == CntFull;
  assign out_valid_o = count_q != '0;
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ATP_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "push into a full result queue")

endmodule

// ===== rtl/ape_tag_item_parser_core.sv =====
// Channel | Valid      | Stall      | Payload
// --------+------------+------------+--------------------------------------------
// in      | in_valid_i | in_stall_o | func_i, data_byte_i
// out     | out_valid_o| out_stall_i| kind_o, footer_ok_o, out_byte_o, item_flags_o,
//         |            |            | item_index_o, key_last_o, item_done_o,
//         |            |            | item_dropped_o, parse_done_o
//
// One byte is accepted per cycle while the result queue has room; each result is
// registered in the result queue before it reaches the output channel.
// in_stall_o rises only when the result queue (QueueDepth entries) is full.
// rst_ni clears all parse state asynchronously; the block then awaits a footer.
module ape_tag_item_parser_core #(
  parameter int unsigned MaxTagBytes = atp_pkg::MAX_TAG_BYTES,
  parameter int unsigned QueueDepth  = atp_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic        footer_ok_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] item_flags_o,
  output logic [31:0] item_index_o,
  output logic        key_last_o,
  output logic        item_done_o,
  output logic        item_dropped_o,
  output logic        parse_done_o
);

  logic          q_full;
  logic          push;
  atp_pkg::res_t push_res;
  atp_pkg::res_t out_res;

  // Front end: parse and classify bytes
  atp_front #(
    .MaxTagBytes(MaxTagBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .data_byte_i(data_byte_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_res_o (push_res)
  );

  // Back end: result queue toward the output channel
  atp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_res),
    .full_o     (q_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_res)
  );

  assign kind_o         = 2'(out_res.kind);
  assign footer_ok_o    = out_res.footer_ok;
  assign out_byte_o     = out_res.out_byte;
  assign item_flags_o   = out_res.item_flags;
  assign item_index_o   = out_res.item_index;
  assign key_last_o     = out_res.key_last;
  assign item_done_o    = out_res.item_done;
  assign item_dropped_o = out_res.item_dropped;
  assign parse_done_o   = out_res.parse_done;

endmodule

// ===== tb/tb.sv =====
module tb;

  typedef enum logic [2:0] {
    STOP_COUNT,
    STOP_SHORT,
    STOP_NO_NUL,
    STOP_OVERRUN,
    STOP_ZERO_COUNT,
    STOP_REJECT
  } stop_e;

  typedef enum logic [1:0] {
    REJ_ID,
    REJ_VERSION,
    REJ_LEN_LOW,
    REJ_LEN_HIGH
  } reject_e;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic        footer_ok_o;
  logic [7:0]  out_byte_o;
  logic [31:0] item_flags_o;
  logic [31:0] item_index_o;
  logic        key_last_o;
  logic        item_done_o;
  logic        item_dropped_o;
  logic        parse_done_o;

  ape_tag_item_parser_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .footer_ok_o    (footer_ok_o),
    .out_byte_o     (out_byte_o),
    .item_flags_o   (item_flags_o),
    .item_index_o   (item_index_o),
    .key_last_o     (key_last_o),
    .item_done_o    (item_done_o),
    .item_dropped_o (item_dropped_o),
    .parse_done_o   (parse_done_o)
  );

  always #10 clk_i = ~clk_i;

  // Expected parser results, oldest first
  atp_pkg::res_t expected_q[$];
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          res_cnt = 0;
  logic        idle_en = 1'b0;

  // Tag plan: body bytes and where each test's share of them ends
  logic [7:0]  body_q[$];
  int          dir_end;
  int          rnd_end;
  int          n_items = 0;
  logic [31:0] tag_len;
  logic [31:0] tag_count;
  logic [31:0] tag_ver = atp_pkg::APE_VERSION;
  stop_e       stop_mode;
  reject_e     reject_mode;

  // Parser prediction state (reset values)
  logic [5:0]  ftr_pos = '0;
  logic        id_ok = 1'b1;
  logic [31:0] ver_word = '0;
  logic [31:0] len_word = '0;
  logic [31:0] items_rem = '0;
  logic [20:0] body_rem = '0;
  atp_pkg::phase_e ph = atp_pkg::PH_FOOTER;
  logic [1:0]  word_idx = '0;
  logic [31:0] val_size = '0;
  logic [31:0] cur_flags = '0;
  logic [31:0] cur_index = '0;
  logic [31:0] val_rem = '0;

  // Start the next tag item, or report the end of parsing
  function automatic logic start_item();
    if (items_rem == 0 || body_rem <= atp_pkg::MIN_BODY_LEFT) begin
      ph = atp_pkg::PH_DONE;
      return 1'b1;
    end
    items_rem = items_rem - 1;
    ph = atp_pkg::PH_SIZE;
    word_idx = '0;
    val_size = '0;
    cur_flags = '0;
    val_rem = '0;
    return 1'b0;
  endfunction

  // Advance the parser prediction by one accepted byte
  task automatic predict_byte(input logic f, input logic [7:0] b);
    atp_pkg::res_t r;
    logic       got;
    logic [4:0] pos;
    logic       ok;
    r = '0;
    got = 1'b0;
    if (ph == atp_pkg::PH_FOOTER) begin
      if (f == 1'b0) begin
        pos = ftr_pos[4:0];
        if (pos < 8) begin
          if (b != atp_pkg::APE_ID[8*pos +: 8]) id_ok = 1'b0;
        end else if (pos < 12) begin
          ver_word = ver_word | (32'(b) << (8 * (pos - 8)));
        end else if (pos < 16) begin
          len_word = len_word | (32'(b) << (8 * (pos - 12)));
        end else if (pos < 20) begin
          items_rem = items_rem | (32'(b) << (8 * (pos - 16)));
        end
        ftr_pos = {1'b0, pos} + 6'd1;
        if (pos == atp_pkg::FOOTER_LAST) begin
          got = 1'b1;
          r.kind = atp_pkg::KIND_VERDICT;
          ok = id_ok && ver_word == atp_pkg::APE_VERSION &&
               len_word > atp_pkg::MIN_TAG_LEN && len_word <= atp_pkg::MAX_TAG_BYTES;
          if (!ok) begin
            ph = atp_pkg::PH_DONE;
            r.parse_done = 1'b1;
          end else begin
            body_rem = 21'(len_word - atp_pkg::FOOTER_BYTES);
            cur_index = '0;
            r.footer_ok = 1'b1;
            r.parse_done = start_item();
          end
        end
      end
    end else if (ph != atp_pkg::PH_DONE && f == 1'b1) begin
      if (body_rem != 0) body_rem = body_rem - 21'd1;
      if (ph == atp_pkg::PH_SIZE || ph == atp_pkg::PH_FLAGS) begin
        // little-endian size and flags words, no result
        if (ph == atp_pkg::PH_SIZE) val_size = val_size | (32'(b) << (8 * word_idx));
        else cur_flags = cur_flags | (32'(b) << (8 * word_idx));
        if (word_idx == 2'd3) begin
          word_idx = '0;
          ph = (ph == atp_pkg::PH_SIZE) ? atp_pkg::PH_FLAGS : atp_pkg::PH_KEY;
        end else begin
          word_idx = word_idx + 2'd1;
        end
      end else if (ph == atp_pkg::PH_KEY) begin
        got = 1'b1;
        r.kind = atp_pkg::KIND_KEY;
        r.out_byte = b;
        r.item_flags = cur_flags;
        r.item_index = cur_index;
        if (b != 8'h00) begin
          // key runs into the end of the body: item dropped
          if (body_rem == 0) begin
            r.item_dropped = 1'b1;
            r.parse_done = 1'b1;
            ph = atp_pkg::PH_DONE;
          end
        end else begin
          r.key_last = 1'b1;
          if (32'(body_rem) < val_size) begin
            r.item_dropped = 1'b1;
            r.parse_done = 1'b1;
            ph = atp_pkg::PH_DONE;
          end else if (val_size == 0) begin
            r.item_done = 1'b1;
            cur_index = cur_index + 1;
            r.parse_done = start_item();
          end else begin
            val_rem = val_size;
            ph = atp_pkg::PH_VALUE;
          end
        end
      end else begin
        got = 1'b1;
        r.kind = atp_pkg::KIND_VALUE;
        r.out_byte = b;
        r.item_flags = cur_flags;
        r.item_index = cur_index;
        if (val_rem != 0) val_rem = val_rem - 1;
        if (val_rem == 0) begin
          r.item_done = 1'b1;
          cur_index = cur_index + 1;
          r.parse_done = start_item();
        end
      end
    end
    if (got) expected_q.push_back(r);
  endtask

  // Send one byte transaction, with an occasional gap ahead of it
  task automatic send_byte(input logic f, input logic [7:0] b);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(f, b);
    sent_cnt++;
  endtask

  // Body bytes from the plan, optionally mixed with footer-type noise
  task automatic send_body_range(input int lo, input int hi, input bit noise);
    for (int i = lo; i < hi; i++) begin
      if (noise && $urandom_range(0, 15) == 0) send_byte(1'b0, 8'($urandom_range(0, 255)));
      send_byte(1'b1, body_q[i]);
    end
  endtask

  // Hold the sender off until every expected result is out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_item(input logic [31:0] vsize, input logic [31:0] flags,
                          input int key_len, input int val_len);
    for (int i = 0; i < 4; i++) body_q.push_back(vsize[8*i +: 8]);
    for (int i = 0; i < 4; i++) body_q.push_back(flags[8*i +: 8]);
    repeat (key_len) body_q.push_back(8'($urandom_range(1, 255)));
    body_q.push_back(8'h00);
    repeat (val_len) body_q.push_back(8'($urandom_range(0, 255)));
    n_items++;
  endtask

  function automatic logic [31:0] pick_flags();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Lay out the whole tag body and the footer fields before sending anything
  task automatic plan_tag();
    logic [31:0] vsize;
    int          vlen;
    int          klen;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) stop_mode = STOP_COUNT;
    else if (pick < 5) stop_mode = STOP_SHORT;
    else if (pick < 7) stop_mode = STOP_NO_NUL;
    else if (pick < 9) stop_mode = STOP_OVERRUN;
    else stop_mode = ($urandom_range(0, 1) == 0) ? STOP_ZERO_COUNT : STOP_REJECT;

    // directed: all-ones flags with empty value, zero flags with one value byte
    add_item(32'd0, 32'hFFFF_FFFF, 2, 0);
    add_item(32'd1, 32'h0000_0000, 2, 1);
    dir_end = body_q.size();

    while (body_q.size() < 760) begin
      vsize = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(25, 80))
                                           : 32'($urandom_range(0, 24));
      add_item(vsize, pick_flags(), $urandom_range(2, 8), int'(vsize));
    end
    rnd_end = body_q.size();

    // the closing item decides how parsing ends
    case (stop_mode)
      STOP_NO_NUL: begin
        vsize = $urandom;
        for (int i = 0; i < 4; i++) body_q.push_back(vsize[8*i +: 8]);
        vsize = pick_flags();
        for (int i = 0; i < 4; i++) body_q.push_back(vsize[8*i +: 8]);
        repeat ($urandom_range(3, 10)) body_q.push_back(8'($urandom_range(1, 255)));
        n_items++;
      end
      STOP_OVERRUN: begin
        vlen = $urandom_range(0, 5);
        case ($urandom_range(0, 2))
          0: vsize = 32'(vlen + 1);
          1: vsize = 32'hFFFF_FFFF;
          default: vsize = 32'(vlen + $urandom_range(2, 1000));
        endcase
        add_item(vsize, pick_flags(), $urandom_range(2, 6), vlen);
      end
      default: begin
        vsize = 32'($urandom_range(0, 12));
        klen = $urandom_range(2, 6);
        add_item(vsize, pick_flags(), klen, int'(vsize));
      end
    endcase

    tag_len = 32'(body_q.size()) + atp_pkg::FOOTER_BYTES;
    tag_count = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
                                            : 32'(n_items + $urandom_range(1, 5));
    case (stop_mode)
      STOP_COUNT: begin
        tag_count = 32'(n_items);
        tag_len = ($urandom_range(0, 1) == 0) ? 32'(atp_pkg::MAX_TAG_BYTES)
                                              : tag_len + 32'($urandom_range(11, 200));
      end
      STOP_SHORT: tag_len = tag_len + 32'($urandom_range(0, atp_pkg::MIN_BODY_LEFT));
      STOP_ZERO_COUNT: tag_count = '0;
      STOP_REJECT: begin
        reject_mode = reject_e'($urandom_range(0, 3));
        case (reject_mode)
          REJ_VERSION: begin
            case ($urandom_range(0, 2))
              0: tag_ver = atp_pkg::APE_VERSION - 1;
              1: tag_ver = atp_pkg::APE_VERSION + 1;
              default: tag_ver = $urandom | 32'h0001_0000;
            endcase
          end
          REJ_LEN_LOW: begin
            tag_len = ($urandom_range(0, 1) == 0) ? atp_pkg::MIN_TAG_LEN
                                                  : 32'($urandom_range(0, 42));
          end
          REJ_LEN_HIGH: begin
            tag_len = ($urandom_range(0, 1) == 0) ? 32'(atp_pkg::MAX_TAG_BYTES + 1)
                                                  : 32'hFFFF_FFFF;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // Footer with its id, version, length and count, plus body-type noise
  task automatic test_footer();
    logic [7:0] foot [32];
    int         bad_pos;
    idle_en <= 1'b1;
    for (int i = 0; i < 8; i++) foot[i] = atp_pkg::APE_ID[8*i +: 8];
    for (int i = 0; i < 4; i++) begin
      foot[8 + i] = tag_ver[8*i +: 8];
      foot[12 + i] = tag_len[8*i +: 8];
      foot[16 + i] = tag_count[8*i +: 8];
    end
    for (int i = 20; i < 32; i++) foot[i] = 8'($urandom_range(0, 255));
    if (stop_mode == STOP_REJECT && reject_mode == REJ_ID) begin
      bad_pos = $urandom_range(0, 7);
      foot[bad_pos] = foot[bad_pos] ^ (8'd1 << $urandom_range(0, 7));
    end
    send_byte(1'b1, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 32; i++) begin
      if ($urandom_range(0, 7) == 0) send_byte(1'b1, 8'($urandom_range(0, 255)));
      send_byte(1'b0, foot[i]);
    end
  endtask

  task automatic test_directed_items();
    send_byte(1'b0, 8'hFF);
    send_body_range(0, dir_end, 1'b0);
  endtask

  // Bulk items in chunks, each chunk with or without idling
  task automatic test_random_items();
    int lo;
    int hi;
    int chunk;
    chunk = 0;
    for (lo = dir_end; lo < rnd_end; lo += 96) begin
      hi = (lo + 96 < rnd_end) ? lo + 96 : rnd_end;
      idle_en <= ($urandom_range(0, 3) != 0);
      send_body_range(lo, hi, 1'b1);
      chunk++;
      if (chunk == 2) drain_results();
    end
  endtask

  task automatic test_stop_case();
    idle_en <= 1'b0;
    send_body_range(rnd_end, body_q.size(), 1'b0);
  endtask

  // Anything after the stop is ignored
  task automatic test_after_stop();
    repeat (16) send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    plan_tag();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_footer();
    test_directed_items();
    test_random_items();
    test_stop_case();
    test_after_stop();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Summary: %0d bytes sent, %0d tag items laid out, %0d results checked",
             sent_cnt, n_items, res_cnt);
    $display("Summary: tag ends by %s", stop_mode.name());
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Random stall bursts on the result side
  logic [4:0] stall_left = '0;
  always @(posedge clk_i) begin
    if (!rst_ni || !idle_en) begin
      out_stall_i <= 1'b0;
      stall_left <= '0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 5'd1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= 5'($urandom_range(0, 17));
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    atp_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      res_cnt++;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual kind %0d byte %0h",
                 $time, kind_o, out_byte_o);
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("footer_ok", want.footer_ok, footer_ok_o);
        check_field("out_byte", want.out_byte, out_byte_o);
        check_field("item_flags", want.item_flags, item_flags_o);
        check_field("item_index", want.item_index, item_index_o);
        check_field("key_last", want.key_last, key_last_o);
        check_field("item_done", want.item_done, item_done_o);
        check_field("item_dropped", want.item_dropped, item_dropped_o);
        check_field("parse_done", want.parse_done, parse_done_o);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  int unsigned quiet_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt == QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/atp_pkg.sv
rtl/atp_front.sv
rtl/atp_queue.sv
rtl/ape_tag_item_parser_core.sv
tb/tb.sv
